/* src/ttr_pkg.sv */
// Shared types and constants for the touch report tracker.
`default_nettype none

package ttr_pkg;

    localparam int MAX_POINTS = 5;
    localparam int NUM_IDS    = 16;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam int STAT_W     = 8;
    localparam int ID_W       = 4;
    localparam int POS_W      = 15;
    localparam int EV_POS_W   = 16;
    localparam int SIZE_W     = 16;

    localparam int ID_LSB     = STAT_W;
    localparam int X_LSB      = ID_LSB + ID_W;
    localparam int Y_LSB      = X_LSB + POS_W;
    localparam int SIZE_LSB   = Y_LSB + POS_W;
    localparam int IN_BITS    = SIZE_LSB + SIZE_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS   = ID_W + 2 * EV_POS_W + SIZE_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [STAT_W-1:0]   READY_MASK = 8'h80;
    localparam logic [STAT_W-1:0]   COUNT_MASK = 8'h0F;
    localparam logic [EV_POS_W-1:0] NO_POS     = '1;

    localparam logic CMD_STATUS = 1'b0;
    localparam logic CMD_POINT  = 1'b1;
    localparam logic KIND_DOWN  = 1'b0;
    localparam logic KIND_UP    = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REL_ALL,
        S_REL_MISS,
        S_DOWN
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SIZE_W-1:0] size;
    } t_point;

    typedef struct packed {
        logic take_status;
        logic take_point;
        logic idx_clr;
        logic idx_inc;
        logic emit_rel;
        logic emit_down;
        logic ev_last;
        logic finish_status;
        logic finish_point;
    } t_cmd;

    typedef struct packed {
        logic st_ok;
        logic st_zero;
        logic pt_ok;
        logic pt_final;
        logic prev_gt;
        logic prev_nz;
        logic idx_last_prev;
        logic idx_last_cnt;
        logic found;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* src/touch_report_tracker.sv */
// Top level of the multitouch report tracker.
// A status beat or a point beat is taken while the controller is idle. The beat that
// completes a report (its last point, or a ready zero-count status after a report with
// points) then stalls the input while events leave through the single event register, at
// most one per cycle and only while the output side accepts: on a last point, a release per
// previous id missing from the report if the previous report had more points, then one down
// per point; on a zero-count status, one release per previous id. Other beats never stall.
`default_nettype none

module touch_report_tracker import ttr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata: status_byte, track_id, x_position, y_position, touch_size, zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: cmd
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata: event_id, event_x, event_y, event_size, zero pad
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // tuser: event_kind
    output logic                       o_m_axis_tuser,
    // tlast: last_event
    output logic                       o_m_axis_tlast
);

    t_cmd                w_cmd;
    t_stat               w_stat;
    logic [ID_W-1:0]     w_id;
    logic [EV_POS_W-1:0] w_x;
    logic [EV_POS_W-1:0] w_y;
    logic [SIZE_W-1:0]   w_size;

    ttr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    ttr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_tuser     (i_s_axis_tuser),
        .i_tdata     (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast),
        .o_out_id    (w_id),
        .o_out_x     (w_x),
        .o_out_y     (w_y),
        .o_out_size  (w_size)
    );

    assign o_m_axis_tdata = OUT_DATA_W'({w_size, w_y, w_x, w_id});

`ifndef SYNTH
    // release beats carry no contact size
    a_up_size_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_UP) |-> (w_size == '0))
        else $error("release beat with nonzero size");

    // down beats carry real positions
    a_down_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_DOWN)
        |-> (!w_x[EV_POS_W-1] && !w_y[EV_POS_W-1]))
        else $error("down beat with negative position");

    // input stays stalled until a report's last event is queued
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input ready while a report is still emitting");
`endif

endmodule

`default_nettype wire

/* src/ttr_dp.sv */
// Datapath: report decode, point buffer, previous ids, last-position store, event register.
`default_nettype none

module ttr_dp import ttr_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    input  wire logic                   i_tuser,
    input  wire logic [IN_DATA_W-1:0]   i_tdata,
    input  wire logic                   i_out_ready,
    output t_stat                       o_stat,
    output logic                        o_out_valid,
    output logic                        o_out_kind,
    output logic                        o_out_last,
    output logic [ID_W-1:0]             o_out_id,
    output logic [EV_POS_W-1:0]         o_out_x,
    output logic [EV_POS_W-1:0]         o_out_y,
    output logic [SIZE_W-1:0]           o_out_size
);

    logic [CNT_W-1:0]    r_expected;
    logic [CNT_W-1:0]    r_received;
    logic [CNT_W-1:0]    r_prev_count;
    logic [CNT_W-1:0]    r_idx;
    t_point              r_buf [MAX_POINTS];
    logic [ID_W-1:0]     r_prev_ids [MAX_POINTS];
    logic [EV_POS_W-1:0] r_last_x [NUM_IDS];
    logic [EV_POS_W-1:0] r_last_y [NUM_IDS];

    logic                r_ov;
    logic                r_okind;
    logic                r_olast;
    logic [ID_W-1:0]     r_oid;
    logic [EV_POS_W-1:0] r_ox;
    logic [EV_POS_W-1:0] r_oy;
    logic [SIZE_W-1:0]   r_osize;

    logic [STAT_W-1:0]   w_status;
    logic [3:0]          w_count;
    t_point              w_in_pt;
    t_point              w_cur_pt;
    logic [ID_W-1:0]     w_prev_id;
    logic                w_found;

    assign w_status   = i_tdata[STAT_W-1:0];
    assign w_count    = 4'(w_status & COUNT_MASK);
    assign w_in_pt.id   = i_tdata[ID_LSB +: ID_W];
    assign w_in_pt.x    = i_tdata[X_LSB +: POS_W];
    assign w_in_pt.y    = i_tdata[Y_LSB +: POS_W];
    assign w_in_pt.size = i_tdata[SIZE_LSB +: SIZE_W];
    assign w_cur_pt   = r_buf[r_idx[IDX_W-1:0]];
    assign w_prev_id  = r_prev_ids[r_idx[IDX_W-1:0]];

    always_comb begin
        w_found = 1'b0;
        for (int j = 0; j < MAX_POINTS; j++) begin
            if (CNT_W'(j) < r_expected && r_buf[j].id == w_prev_id) begin
                w_found = 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.st_ok         = (i_tuser == CMD_STATUS) && ((w_status & READY_MASK) != '0)
                               && (w_count <= 4'(MAX_POINTS));
        o_stat.st_zero       = o_stat.st_ok && (w_count == '0);
        o_stat.pt_ok         = (i_tuser == CMD_POINT) && (r_expected != '0)
                               && (r_received < r_expected);
        o_stat.pt_final      = o_stat.pt_ok && (CNT_W'(r_received + CNT_W'(1)) == r_expected);
        o_stat.prev_gt       = r_prev_count > r_expected;
        o_stat.prev_nz       = r_prev_count != '0;
        o_stat.idx_last_prev = r_idx == CNT_W'(r_prev_count - CNT_W'(1));
        o_stat.idx_last_cnt  = r_idx == CNT_W'(r_expected - CNT_W'(1));
        o_stat.found         = w_found;
        o_stat.out_free      = !r_ov || i_out_ready;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected   <= '0;
            r_received   <= '0;
            r_prev_count <= '0;
            r_idx        <= '0;
            r_ov         <= 1'b0;
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_prev_ids[k] <= '0;
            end
            for (int k = 0; k < NUM_IDS; k++) begin
                r_last_x[k] <= NO_POS;
                r_last_y[k] <= NO_POS;
            end
        end else begin
            if (i_cmd.take_status) begin
                r_expected <= CNT_W'(w_count);
                r_received <= '0;
            end
            if (i_cmd.take_point) begin
                r_received <= CNT_W'(r_received + CNT_W'(1));
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= CNT_W'(r_idx + CNT_W'(1));
            end
            if (i_cmd.finish_status) begin
                r_prev_count <= '0;
            end
            if (i_cmd.finish_point) begin
                r_prev_count <= r_expected;
                r_expected   <= '0;
                r_received   <= '0;
            end
            if (i_cmd.emit_rel) begin
                r_last_x[w_prev_id] <= NO_POS;
                r_last_y[w_prev_id] <= NO_POS;
            end else if (i_cmd.emit_down) begin
                r_last_x[w_cur_pt.id] <= EV_POS_W'(w_cur_pt.x);
                r_last_y[w_cur_pt.id] <= EV_POS_W'(w_cur_pt.y);
                r_prev_ids[r_idx[IDX_W-1:0]] <= w_cur_pt.id;
            end
            if (i_cmd.emit_rel || i_cmd.emit_down) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_point) begin
            r_buf[r_received[IDX_W-1:0]] <= w_in_pt;
        end
        if (i_cmd.emit_rel) begin
            r_okind <= KIND_UP;
            r_olast <= i_cmd.ev_last;
            r_oid   <= w_prev_id;
            r_ox    <= r_last_x[w_prev_id];
            r_oy    <= r_last_y[w_prev_id];
            r_osize <= '0;
        end else if (i_cmd.emit_down) begin
            r_okind <= KIND_DOWN;
            r_olast <= i_cmd.ev_last;
            r_oid   <= w_cur_pt.id;
            r_ox    <= EV_POS_W'(w_cur_pt.x);
            r_oy    <= EV_POS_W'(w_cur_pt.y);
            r_osize <= w_cur_pt.size;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_kind  = r_okind;
    assign o_out_last  = r_olast;
    assign o_out_id    = r_oid;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_size  = r_osize;

endmodule

`default_nettype wire

/* src/ttr_ctrl.sv */
// Controller: input acceptance and the release and down event sequence.
`default_nettype none

module ttr_ctrl import ttr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_stat i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.st_zero && i_stat.prev_nz) begin
                        n_state = S_REL_ALL;
                    end else if (i_stat.pt_final) begin
                        n_state = i_stat.prev_gt ? S_REL_MISS : S_DOWN;
                    end
                end
            end
            S_REL_ALL: begin
                if (i_stat.out_free && i_stat.idx_last_prev) begin
                    n_state = S_IDLE;
                end
            end
            S_REL_MISS: begin
                if ((i_stat.found || i_stat.out_free) && i_stat.idx_last_prev) begin
                    n_state = S_DOWN;
                end
            end
            S_DOWN: begin
                if (i_stat.out_free && i_stat.idx_last_cnt) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_status = i_stat.st_ok;
                    o_cmd.take_point  = i_stat.pt_ok;
                    o_cmd.idx_clr     = (i_stat.st_zero && i_stat.prev_nz) || i_stat.pt_final;
                end
            end
            S_REL_ALL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_rel      = 1'b1;
                    o_cmd.ev_last       = i_stat.idx_last_prev;
                    o_cmd.finish_status = i_stat.idx_last_prev;
                    o_cmd.idx_inc       = !i_stat.idx_last_prev;
                end
            end
            S_REL_MISS: begin
                if (i_stat.found || i_stat.out_free) begin
                    o_cmd.emit_rel = !i_stat.found;
                    o_cmd.idx_clr  = i_stat.idx_last_prev;
                    o_cmd.idx_inc  = !i_stat.idx_last_prev;
                end
            end
            S_DOWN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_down    = 1'b1;
                    o_cmd.ev_last      = i_stat.idx_last_cnt;
                    o_cmd.finish_point = i_stat.idx_last_cnt;
                    o_cmd.idx_inc      = !i_stat.idx_last_cnt;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* verif/touch_report_tracker_tb.sv */
// Self-checking testbench for the touch report tracker: directed and random reports.
module touch_report_tracker_tb import ttr_pkg::*; ();

    localparam int ITEMS       = 410;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 4 * MAX_POINTS + 20;
    localparam int EV_X_LSB    = ID_W;
    localparam int EV_Y_LSB    = ID_W + EV_POS_W;
    localparam int EV_SIZE_LSB = ID_W + 2 * EV_POS_W;

    typedef struct {
        logic                kind;
        logic [ID_W-1:0]     id;
        logic [EV_POS_W-1:0] x;
        logic [EV_POS_W-1:0] y;
        logic [SIZE_W-1:0]   size;
        logic                last;
    } t_touch_event;

    class touch_event_ledger;
        int             exp_pts;
        int             rcv_pts;
        t_point         pts[MAX_POINTS];
        logic [ID_W-1:0] prev_ids[MAX_POINTS];
        int             prev_cnt;
        logic [EV_POS_W-1:0] last_x[NUM_IDS];
        logic [EV_POS_W-1:0] last_y[NUM_IDS];
        t_touch_event   batch[$];
        t_touch_event   pending_events[$];
        int             mismatch_count;
        int             events_checked;

        function new();
            exp_pts = 0;
            rcv_pts = 0;
            prev_cnt = 0;
            mismatch_count = 0;
            events_checked = 0;
            foreach (prev_ids[i]) prev_ids[i] = '0;
            foreach (last_x[i]) begin
                last_x[i] = NO_POS;
                last_y[i] = NO_POS;
            end
        endfunction

        function void lift_id(logic [ID_W-1:0] id);
            t_touch_event ev;
            ev.kind = KIND_UP;
            ev.id   = id;
            ev.x    = last_x[id];
            ev.y    = last_y[id];
            ev.size = '0;
            ev.last = 1'b0;
            batch.push_back(ev);
            last_x[id] = NO_POS;
            last_y[id] = NO_POS;
        endfunction

        // Returns 1 when the beat changes state or causes events.
        function bit take_beat(logic cmd, logic [IN_DATA_W-1:0] d);
            logic [STAT_W-1:0] st;
            int               cnt;
            bit               found;
            t_point           p;
            t_touch_event     ev;
            st = d[STAT_W-1:0];
            batch.delete();
            if (cmd == CMD_STATUS) begin
                cnt = int'(st & COUNT_MASK);
                if (st == '0 || (st & READY_MASK) == '0 || cnt > MAX_POINTS) return 0;
                if (cnt > 0) begin
                    exp_pts = cnt;
                    rcv_pts = 0;
                    return 1;
                end
                exp_pts = 0;
                rcv_pts = 0;
                for (int i = 0; i < prev_cnt; i++) lift_id(prev_ids[i]);
                prev_cnt = 0;
            end else begin
                if (exp_pts == 0 || rcv_pts >= exp_pts) return 0;
                p.id   = d[ID_LSB +: ID_W];
                p.x    = d[X_LSB +: POS_W];
                p.y    = d[Y_LSB +: POS_W];
                p.size = d[SIZE_LSB +: SIZE_W];
                pts[rcv_pts] = p;
                rcv_pts++;
                if (rcv_pts < exp_pts) return 1;
                if (prev_cnt > exp_pts) begin
                    for (int i = 0; i < prev_cnt; i++) begin
                        found = 0;
                        for (int j = 0; j < exp_pts; j++)
                            if (pts[j].id == prev_ids[i]) found = 1;
                        if (!found) lift_id(prev_ids[i]);
                    end
                end
                for (int i = 0; i < exp_pts; i++) begin
                    prev_ids[i] = pts[i].id;
                    ev.kind = KIND_DOWN;
                    ev.id   = pts[i].id;
                    ev.x    = {1'b0, pts[i].x};
                    ev.y    = {1'b0, pts[i].y};
                    ev.size = pts[i].size;
                    ev.last = 1'b0;
                    batch.push_back(ev);
                    last_x[pts[i].id] = {1'b0, pts[i].x};
                    last_y[pts[i].id] = {1'b0, pts[i].y};
                end
                prev_cnt = exp_pts;
                exp_pts = 0;
                rcv_pts = 0;
            end
            if (batch.size() > 0) begin
                ev = batch[batch.size() - 1];
                ev.last = 1'b1;
                batch[batch.size() - 1] = ev;
            end
            foreach (batch[i]) pending_events.push_back(batch[i]);
            return 1;
        endfunction

        function void check_event(logic kind, logic [OUT_DATA_W-1:0] d, logic last);
            t_touch_event want;
            t_touch_event got;
            got.kind = kind;
            got.id   = d[ID_W-1:0];
            got.x    = d[EV_X_LSB +: EV_POS_W];
            got.y    = d[EV_Y_LSB +: EV_POS_W];
            got.size = d[EV_SIZE_LSB +: SIZE_W];
            got.last = last;
            events_checked++;
            if (pending_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected event: kind=%0d id=%0d x=%0d y=%0d size=%0d last=%0d",
                             got.kind, got.id, $signed(got.x), $signed(got.y), got.size,
                             got.last);
                return;
            end
            want = pending_events.pop_front();
            if (got.kind !== want.kind || got.id !== want.id || got.x !== want.x ||
                got.y !== want.y || got.size !== want.size || got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("event mismatch: expected kind=%0d id=%0d x=%0d y=%0d size=%0d ",
                             want.kind, want.id, $signed(want.x), $signed(want.y), want.size,
                             "last=%0d, got kind=%0d id=%0d x=%0d y=%0d size=%0d last=%0d",
                             want.last, got.kind, got.id, $signed(got.x), $signed(got.y),
                             got.size, got.last);
            end
        endfunction

        function int pending_count();
            return pending_events.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;   // status_byte, track_id, x, y, size, pad
    logic                  i_s_axis_tuser = 1'b0;  // cmd
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;         // event_id, event_x, event_y, event_size, pad
    logic                  o_m_axis_tuser;         // event_kind
    logic                  o_m_axis_tlast;         // last_event

    touch_event_ledger ledger = new();

    int send_idle_pct = 22;
    int recv_idle_pct = 55;
    int hold_request  = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int beats_sent    = 0;
    int effective     = 0;
    int status_beats  = 0;
    int point_beats   = 0;

    touch_report_tracker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // event sink with random backpressure and one long hold-off
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1)
            ledger.check_event(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid === 1'b1 && o_s_axis_tready === 1'b1) ||
            (o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input logic cmd, input logic [IN_DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (o_s_axis_tready !== 1'b1) @(posedge i_clk);
        beats_sent++;
        if (cmd == CMD_STATUS) status_beats++;
        else point_beats++;
        if (ledger.take_beat(cmd, data)) effective++;
    endtask

    task automatic send_status(input logic [STAT_W-1:0] st);
        logic [IN_DATA_W-1:0] w;
        w = {$urandom, $urandom};
        w[IN_DATA_W-1:IN_BITS] = '0;
        w[STAT_W-1:0] = st;
        send_beat(CMD_STATUS, w);
    endtask

    task automatic send_point(input logic [ID_W-1:0] id, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic [SIZE_W-1:0] sz);
        logic [IN_DATA_W-1:0] w;
        w = '0;
        w[STAT_W-1:0]         = STAT_W'($urandom);
        w[ID_LSB +: ID_W]     = id;
        w[X_LSB +: POS_W]     = x;
        w[Y_LSB +: POS_W]     = y;
        w[SIZE_LSB +: SIZE_W] = sz;
        send_beat(CMD_POINT, w);
    endtask

    task automatic send_random_point(input bit wide_ids);
        logic [ID_W-1:0] id;
        id = wide_ids ? ID_W'($urandom_range(NUM_IDS - 1)) : ID_W'($urandom_range(MAX_POINTS));
        send_point(id, POS_W'($urandom), POS_W'($urandom), SIZE_W'($urandom));
    endtask

    initial begin
        int phase;
        int pick;
        int cnt;
        int sent_pts;
        bit wide_ids;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ignored beats: stray point, zero status, ready clear, count too large
        send_point(4'd3, 15'd100, 15'd200, 16'd300);
        send_status(8'h00);
        send_status(8'h05);
        send_status(8'h86);
        send_status(8'h80);
        // single point at field extremes
        send_status(8'h81);
        send_point(4'd15, 15'h7FFF, 15'h0000, 16'hFFFF);
        // full report; previous count is smaller, so no releases
        send_status(8'h85);
        send_point(4'd0, 15'h0000, 15'h7FFF, 16'h0000);
        send_point(4'd1, 15'h7FFF, 15'h7FFF, 16'hFFFF);
        send_point(4'd2, 15'h2AAA, 15'h5555, 16'hAAAA);
        send_point(4'd3, 15'h5555, 15'h2AAA, 16'h5555);
        send_point(4'd4, 15'h0001, 15'h4000, 16'h8001);
        // shrink to a duplicated id: missing ids released
        send_status(8'h82);
        send_point(4'd2, 15'h1234, 15'h0F0F, 16'h0101);
        send_point(4'd2, 15'h4321, 15'h7070, 16'h0202);
        // drop the duplicate: second release of the same id reports no position
        send_status(8'h81);
        send_point(4'd9, 15'h0808, 15'h1010, 16'h2020);
        // pending report abandoned by a new status with upper bits set
        send_status(8'h83);
        send_point(4'd5, 15'h0111, 15'h0222, 16'h0333);
        send_status(8'hF2);
        send_point(4'd6, 15'h7FFE, 15'h0002, 16'h7FFF);
        send_point(4'd7, 15'h0003, 15'h7FFD, 16'h8000);
        // release all, then oversized count with every bit set
        send_status(8'h80);
        send_status(8'hFF);

        phase = 0;
        while (effective < ITEMS) begin
            if (phase < 2 && effective >= (2 * ITEMS) / 3) begin
                phase = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request = HOLD_CYCLES;
            end else if (phase < 1 && effective >= ITEMS / 3) begin
                phase = 1;
                send_idle_pct = 55;
                recv_idle_pct = 22;
            end
            pick = $urandom_range(99);
            wide_ids = ($urandom_range(3) == 0);
            if (pick < 70) begin
                cnt = $urandom_range(MAX_POINTS, 1);
                send_status(STAT_W'(READY_MASK | ($urandom_range(7) << 4) | cnt));
                for (int i = 0; i < cnt; i++) send_random_point(wide_ids);
            end else if (pick < 82) begin
                send_status(STAT_W'(READY_MASK | ($urandom_range(7) << 4)));
            end else if (pick < 88) begin
                cnt = $urandom_range(MAX_POINTS, 2);
                sent_pts = $urandom_range(cnt - 1);
                send_status(STAT_W'(READY_MASK | ($urandom_range(7) << 4) | cnt));
                for (int i = 0; i < sent_pts; i++) send_random_point(wide_ids);
            end else if (pick < 94) begin
                case ($urandom_range(2))
                    0: send_status(8'h00);
                    1: send_status(STAT_W'($urandom_range(127, 1)));
                    default: send_status(STAT_W'(READY_MASK | ($urandom_range(7) << 4) |
                                                 $urandom_range(15, MAX_POINTS + 1)));
                endcase
            end else begin
                send_random_point(1'b1);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (ledger.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d input beats (%0d status, %0d point), ",
                 beats_sent, status_beats, point_beats,
                 "%0d effective; %0d events checked", effective, ledger.events_checked);
        $display("pacing: sender/receiver idle 22/55, then 55/22, then none with one long hold-off");
        if (ledger.mismatch_count == 0 && ledger.pending_count() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d events outstanding", ledger.mismatch_count,
                     ledger.pending_count());
            $display("FAIL");
        end
        $finish;
    end

endmodule
